### hw/rtl/gat_pkg.sv
// Shared types and constants of the group affiliation table.
package gat_pkg;
  localparam int FUNC_W   = 2;
  localparam int RADIO_W  = 24;
  localparam int GROUP_W  = 16;
  localparam int TIME_W   = 32;
  localparam int TTL_W    = 17;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 9;
  localparam int COUNT_W  = 10;
  localparam logic [TTL_W-1:0] TTL_RESET = 17'd1800;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_REFRESHED = 3'd2,
    ST_REPLACED  = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_TICK_DONE = 3'd6
  } status_t;

  // Classified command from the front part.
  typedef struct packed {
    logic               is_tick;
    logic               is_add;
    logic               is_remove;
    logic [RADIO_W-1:0] radio;
    logic [GROUP_W-1:0] group;
    logic [TIME_W-1:0]  now;
  } cmd_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SCAN,
    EX_SCAN_LAST,
    EX_WRITE,
    EX_DONE
  } ex_state_t;
endpackage

### hw/rtl/gat_if.sv
// Valid/ready channel interfaces for input items and results.
interface gat_in_if;
  logic                       valid;
  logic                       ready;
  logic [gat_pkg::FUNC_W-1:0] func;
  logic [gat_pkg::RADIO_W-1:0] radio_id;
  logic [gat_pkg::GROUP_W-1:0] talkgroup;
  logic [gat_pkg::TIME_W-1:0] now_seconds;
  modport source (output valid, func, radio_id, talkgroup, now_seconds, input ready);
  modport sink (input valid, func, radio_id, talkgroup, now_seconds, output ready);
endinterface

interface gat_out_if;
  logic                         valid;
  logic                         ready;
  logic [gat_pkg::STATUS_W-1:0] status;
  logic [gat_pkg::SLOT_W-1:0]   slot;
  logic [gat_pkg::COUNT_W-1:0]  entries_used;
  logic [gat_pkg::COUNT_W-1:0]  expired_count;
  modport source (output valid, status, slot, entries_used, expired_count, input ready);
  modport sink (input valid, status, slot, entries_used, expired_count, output ready);
endinterface

### hw/rtl/gat_front.sv
// Front part: accepts items, classifies them and holds a two-deep command queue.
module gat_front (
  input  logic               clk,
  input  logic               rst_n,
  gat_in_if.sink             in_ch,
  output gat_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output logic               cmd_ignored
);
  import gat_pkg::*;

  cmd_t       q_r [2];
  logic       ign_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  cmd_t       c;
  logic       ig;
  logic       push, pop;

  always_comb begin
    c.is_tick   = (in_ch.func == FUNC_TICK);
    c.is_add    = (in_ch.func == FUNC_ADD);
    c.is_remove = (in_ch.func == FUNC_REMOVE);
    c.radio     = in_ch.radio_id;
    c.group     = in_ch.talkgroup;
    c.now       = in_ch.now_seconds;
    ig = !c.is_tick && (!(c.is_add || c.is_remove) || in_ch.radio_id == '0 ||
         in_ch.talkgroup == '0);
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_r];
  assign cmd_ignored = ign_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = pop ? !rd_r : rd_r;
    wr_nxt  = push ? !wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r]   <= c;
      ign_r[wr_r] <= ig;
    end
  end
endmodule

### hw/rtl/gat_back.sv
// Back part: scans the table memory once per command that is not ignored and applies the update.
module gat_back #(
  parameter int ENTRIES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gat_pkg::cmd_t         cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic                  cmd_ignored,
  input  logic [gat_pkg::TTL_W-1:0] ttl,
  gat_out_if.source             out_ch
);
  import gat_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENT_W = RADIO_W + GROUP_W + TIME_W;

  // Entry memory; a clearing pass after reset zeroes it.
  logic [ENT_W-1:0] mem [ENTRIES];
  logic [ENT_W-1:0] rd_q;

  ex_state_t st_r, st_nxt;
  logic [IDX_W-1:0] ra_r, ra_nxt;   // read address
  logic [IDX_W-1:0] ci_r, ci_nxt;   // index of entry in rd_q
  logic             clr_r, clr_nxt;
  logic [IDX_W-1:0] clr_a_r, clr_a_nxt;
  cmd_t             c_r, c_nxt;
  logic             found_r, found_nxt, hf_r, hf_nxt;
  logic [IDX_W-1:0] match_r, match_nxt, free_r, free_nxt, old_r, old_nxt;
  logic [TIME_W-1:0] old_t_r, old_t_nxt;
  logic [CNT_W-1:0] used_r, used_nxt, exp_r, exp_nxt;
  logic             ov_r, ov_nxt;
  logic [STATUS_W-1:0] os_r, os_nxt;
  logic [SLOT_W-1:0]   osl_r, osl_nxt;
  logic [COUNT_W-1:0]  ou_r, ou_nxt, oe_r, oe_nxt;
  logic                we;
  logic [IDX_W-1:0]    wa;
  logic [ENT_W-1:0]    wd;

  logic [RADIO_W-1:0] e_radio;
  logic [GROUP_W-1:0] e_group;
  logic [TIME_W-1:0]  e_seen;
  logic               e_occ, e_exp;
  logic [TIME_W:0]    age;
  logic [IDX_W-1:0]   slot_sel;

  assign {e_radio, e_group, e_seen} = rd_q;
  assign e_occ = (e_radio != '0) && (e_group != '0);
  assign age   = {1'b0, c_r.now} - {1'b0, e_seen};
  assign e_exp = e_occ && e_seen != '0 && c_r.now > e_seen &&
                 age > {{(TIME_W + 1 - TTL_W){1'b0}}, ttl};

  // A new command is taken only once the previous result has left the output register.
  assign cmd_ready       = !clr_r && (st_r == EX_IDLE) && !ov_r;
  assign out_ch.valid    = ov_r;
  assign out_ch.status   = os_r;
  assign out_ch.slot     = osl_r;
  assign out_ch.entries_used  = ou_r;
  assign out_ch.expired_count = oe_r;

  always_comb begin
    st_nxt = st_r; ra_nxt = ra_r; ci_nxt = ci_r; c_nxt = c_r;
    clr_nxt = clr_r; clr_a_nxt = clr_a_r;
    found_nxt = found_r; hf_nxt = hf_r; match_nxt = match_r; free_nxt = free_r;
    old_nxt = old_r; old_t_nxt = old_t_r; used_nxt = used_r; exp_nxt = exp_r;
    ov_nxt = ov_r; os_nxt = os_r; osl_nxt = osl_r; ou_nxt = ou_r; oe_nxt = oe_r;
    we = 1'b0; wa = ci_r; wd = '0; slot_sel = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    if (clr_r) begin
      we = 1'b1; wa = clr_a_r;
      clr_a_nxt = clr_a_r + 1'b1;
      if (clr_a_r == IDX_W'(ENTRIES - 1)) clr_nxt = 1'b0;
    end else begin
      case (st_r)
        EX_IDLE: begin
          if (cmd_valid && !ov_r) begin
            c_nxt = cmd;
            if (cmd_ignored) begin
              os_nxt = ST_IGNORED; osl_nxt = '0; oe_nxt = '0;
              ou_nxt = COUNT_W'(used_r);
              st_nxt = EX_DONE;
            end else begin
              ra_nxt = IDX_W'(1); ci_nxt = '0;
              found_nxt = 1'b0; hf_nxt = 1'b0; old_nxt = '0;
              exp_nxt = '0;
              st_nxt = EX_SCAN;
            end
          end
        end
        EX_SCAN, EX_SCAN_LAST: begin
          // rd_q holds entry ci_r
          if (c_r.is_tick) begin
            if (e_exp) begin
              we = 1'b1; wa = ci_r; wd = '0;
              exp_nxt = exp_r + 1'b1;
              if (used_nxt != '0) used_nxt = used_nxt - 1'b1;
            end
          end else begin
            if (!found_r && e_radio == c_r.radio && e_group == c_r.group) begin
              found_nxt = 1'b1; match_nxt = ci_r;
            end
            if (!hf_r && !e_occ) begin
              hf_nxt = 1'b1; free_nxt = ci_r;
            end
            if (ci_r == '0 || e_seen < old_t_r) begin
              old_nxt = ci_r; old_t_nxt = e_seen;
            end
          end
          ci_nxt = ci_r + 1'b1;
          ra_nxt = ra_r + 1'b1;
          if (st_r == EX_SCAN_LAST) st_nxt = EX_WRITE;
          else if (ci_r == IDX_W'(ENTRIES - 2)) st_nxt = EX_SCAN_LAST;
        end
        EX_WRITE: begin
          oe_nxt = '0; osl_nxt = '0;
          if (c_r.is_tick) begin
            os_nxt = ST_TICK_DONE;
            oe_nxt = COUNT_W'(exp_r);
          end else if (c_r.is_add) begin
            we = 1'b1;
            if (found_r) begin
              slot_sel = match_r; os_nxt = ST_REFRESHED;
            end else if (hf_r) begin
              slot_sel = free_r; os_nxt = ST_ADDED;
              used_nxt = used_r + 1'b1;
            end else begin
              slot_sel = old_r; os_nxt = ST_REPLACED;
            end
            wa = slot_sel;
            wd = {c_r.radio, c_r.group, c_r.now};
            osl_nxt = SLOT_W'(slot_sel);
          end else begin
            if (found_r) begin
              we = 1'b1; wa = match_r; wd = '0;
              os_nxt = ST_REMOVED; osl_nxt = SLOT_W'(match_r);
              if (used_r != '0) used_nxt = used_r - 1'b1;
            end else begin
              os_nxt = ST_NOT_FOUND;
            end
          end
          ou_nxt = COUNT_W'(used_nxt);
          st_nxt = EX_DONE;
        end
        EX_DONE: begin
          if (!ov_r) begin
            ov_nxt = 1'b1;
            st_nxt = EX_IDLE;
          end
        end
        default: st_nxt = EX_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= EX_IDLE; clr_r <= 1'b1; clr_a_r <= '0; used_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; clr_a_r <= clr_a_nxt; used_r <= used_nxt;
      ov_r <= ov_nxt;
    end
    ra_r <= ra_nxt; ci_r <= ci_nxt; c_r <= c_nxt;
    found_r <= found_nxt; hf_r <= hf_nxt; match_r <= match_nxt; free_r <= free_nxt;
    old_r <= old_nxt; old_t_r <= old_t_nxt; exp_r <= exp_nxt;
    os_r <= os_nxt; osl_r <= osl_nxt; ou_r <= ou_nxt; oe_r <= oe_nxt;
  end

  // Read address: entry 0 when a scan starts, else the running address.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[(st_r == EX_IDLE) ? '0 : ra_r];
  end
endmodule

### hw/rtl/group_affiliation_table_unit.sv
// Top level of the group affiliation table.
// An add, remove or tick item passes through the front queue; the back part then scans the
// memory one entry per cycle, writes the update and registers the result. An ignored item skips the scan.
// Items are handled one at a time; a command starts the cycle after the previous result
// transfers.
// Reset: synchronous active low, ttl to 1800; then a clearing pass zeroes every entry.
module group_affiliation_table_unit #(
  parameter int ENTRIES = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gat_in_if.sink                    in_ch,
  gat_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [gat_pkg::TTL_W-1:0] cfg_wdata
);
  import gat_pkg::*;

  // The time-to-live register is written whenever the enable is high.
  logic [TTL_W-1:0] ttl_r;
  cmd_t             cmd;
  logic             cmd_valid, cmd_ready, cmd_ignored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_we) begin
      ttl_r <= cfg_wdata;
    end
  end

  // The front part takes each transfer and classifies it into the queue.
  gat_front u_front (
    .clk, .rst_n, .in_ch,
    .cmd, .cmd_valid, .cmd_ready, .cmd_ignored
  );

  // The back part scans the table and returns one result per command.
  gat_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_ready, .cmd_ignored,
    .ttl(ttl_r), .out_ch
  );
endmodule
